// ===== rtl/crmp_pkg.sv =====
package crmp_pkg;

    localparam int PAL_DEPTH = 16;
    localparam int IDX_W     = $clog2(PAL_DEPTH);
    localparam int FRAC_W    = 16;
    localparam int POS_W     = FRAC_W + 1;
    localparam int CH_W      = 8;
    localparam int N_CH      = 3;
    localparam int ENTRY_W   = N_CH * CH_W;
    localparam int COUNT_W   = 5;
    localparam int WIDX_W    = 4;
    // signed (CH_W+1) difference times signed (POS_W+1) weight
    localparam int MIX_W     = CH_W + FRAC_W + 3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } crmp_op_t;

    // read addresses and weight of one lookup
    typedef struct packed
    {
        logic [IDX_W-1:0] lo_idx;
        logic [IDX_W-1:0] up_idx;
        logic [POS_W-1:0] weight;
    } crmp_addr_t;

endpackage

// ===== rtl/crmp_in_if.sv =====
interface crmp_in_if;
    logic                             valid;
    logic                             ready;
    crmp_pkg::crmp_op_t               operation;
    logic [crmp_pkg::POS_W-1:0]       position;
    logic [crmp_pkg::WIDX_W-1:0]      write_index;
    logic [crmp_pkg::CH_W-1:0]        write_red;
    logic [crmp_pkg::CH_W-1:0]        write_green;
    logic [crmp_pkg::CH_W-1:0]        write_blue;

    modport source
    (
        output valid, operation, position, write_index, write_red, write_green, write_blue,
        input  ready
    );

    modport sink
    (
        input  valid, operation, position, write_index, write_red, write_green, write_blue,
        output ready
    );
endinterface

// ===== rtl/crmp_out_if.sv =====
interface crmp_out_if;
    logic                      valid;
    logic                      ready;
    logic [crmp_pkg::CH_W-1:0] red;
    logic [crmp_pkg::CH_W-1:0] green;
    logic [crmp_pkg::CH_W-1:0] blue;

    modport source
    (
        output valid, red, green, blue,
        input  ready
    );

    modport sink
    (
        input  valid, red, green, blue,
        output ready
    );
endinterface

// ===== rtl/crmp_addr.sv =====
module crmp_addr
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [crmp_pkg::COUNT_W-1:0]     entry_count,
    input  logic [crmp_pkg::POS_W-1:0]       position,
    output crmp_pkg::crmp_addr_t             addr
);

    localparam int S_W = crmp_pkg::FRAC_W + crmp_pkg::IDX_W;

    logic [crmp_pkg::COUNT_W-1:0] count_eff;
    logic [crmp_pkg::COUNT_W-1:0] imax_full;
    logic [crmp_pkg::IDX_W-1:0]   imax;
    logic [S_W-1:0]               scaled;
    logic [S_W:0]                 ceil_sum;
    logic [crmp_pkg::IDX_W:0]     upper_raw;
    logic [crmp_pkg::IDX_W-1:0]   upper;
    logic [crmp_pkg::IDX_W-1:0]   lower;
    logic [S_W-1:0]               frac_full;

    // clamp the count to 1..depth
    always_comb
    begin
        if (entry_count == '0)
        begin
            count_eff = crmp_pkg::COUNT_W'(1);
        end
        else if (entry_count > crmp_pkg::COUNT_W'(crmp_pkg::PAL_DEPTH))
        begin
            count_eff = crmp_pkg::COUNT_W'(crmp_pkg::PAL_DEPTH);
        end
        else
        begin
            count_eff = entry_count;
        end
    end

    assign imax_full = count_eff - crmp_pkg::COUNT_W'(1);
    assign imax      = imax_full[crmp_pkg::IDX_W-1:0];

    assign scaled    = S_W'(position[crmp_pkg::FRAC_W-1:0]) * S_W'(imax);
    assign ceil_sum  = {1'b0, scaled} + (S_W+1)'((1 << crmp_pkg::FRAC_W) - 1);
    assign upper_raw = ceil_sum[S_W:crmp_pkg::FRAC_W];

    always_comb
    begin
        if (upper_raw > {1'b0, imax})
        begin
            upper = imax;
        end
        else if (upper_raw == '0)
        begin
            upper = crmp_pkg::IDX_W'(1);
        end
        else
        begin
            upper = upper_raw[crmp_pkg::IDX_W-1:0];
        end
    end

    assign lower     = upper - crmp_pkg::IDX_W'(1);
    assign frac_full = scaled - {lower, crmp_pkg::FRAC_W'(0)};

    // end points read the same entry twice with zero weight
    always_comb
    begin
        if (position == '0 || imax == '0)
        begin
            addr.lo_idx = '0;
            addr.up_idx = '0;
            addr.weight = '0;
        end
        else if (position[crmp_pkg::POS_W-1])
        begin
            addr.lo_idx = imax;
            addr.up_idx = imax;
            addr.weight = '0;
        end
        else
        begin
            addr.lo_idx = lower;
            addr.up_idx = upper;
            addr.weight = frac_full[crmp_pkg::POS_W-1:0];
        end
    end

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        addr.weight <= crmp_pkg::POS_W'(1 << crmp_pkg::FRAC_W))
        else $error("interpolation weight above one");

    a_idx_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (addr.up_idx == addr.lo_idx) ||
        (addr.up_idx == addr.lo_idx + crmp_pkg::IDX_W'(1)))
        else $error("lookup indexes not adjacent");

    a_idx_in_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        addr.up_idx <= imax)
        else $error("upper index beyond ramp");

endmodule

// ===== rtl/crmp_palette_ram.sv =====
module crmp_palette_ram
(
    input  logic                              clk,
    input  logic                              we,
    input  logic [crmp_pkg::IDX_W-1:0]        waddr,
    input  logic [crmp_pkg::ENTRY_W-1:0]      wdata,
    input  logic                              re,
    input  logic [crmp_pkg::IDX_W-1:0]        raddr_a,
    input  logic [crmp_pkg::IDX_W-1:0]        raddr_b,
    output logic [crmp_pkg::ENTRY_W-1:0]      rdata_a,
    output logic [crmp_pkg::ENTRY_W-1:0]      rdata_b
);

    logic [crmp_pkg::ENTRY_W-1:0] mem [crmp_pkg::PAL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data while the first stage is stalled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/crmp_mix.sv =====
module crmp_mix
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [crmp_pkg::POS_W-1:0]     weight,
    input  logic [crmp_pkg::ENTRY_W-1:0]   lo_entry,
    input  logic [crmp_pkg::ENTRY_W-1:0]   up_entry,
    output logic                           advance,
    crmp_out_if.source                     rsp
);

    localparam int HI_W = crmp_pkg::MIX_W - crmp_pkg::CH_W - crmp_pkg::FRAC_W;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic [crmp_pkg::POS_W-1:0]          w1_reg;
    logic [crmp_pkg::CH_W-1:0]           lo2_reg   [crmp_pkg::N_CH];
    logic [crmp_pkg::CH_W-1:0]           lo2_next  [crmp_pkg::N_CH];
    logic signed [crmp_pkg::MIX_W-1:0]   prod2_reg [crmp_pkg::N_CH];
    logic signed [crmp_pkg::MIX_W-1:0]   prod2_next[crmp_pkg::N_CH];
    logic [crmp_pkg::CH_W-1:0]           col3_reg  [crmp_pkg::N_CH];
    logic [crmp_pkg::CH_W-1:0]           col3_next [crmp_pkg::N_CH];

    // each stage moves when the one after it is empty or moving
    assign en3     = !v3_reg || rsp.ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign advance = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= load;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // lo + (up - lo) * w, one product per channel
    always_comb
    begin
        logic signed [crmp_pkg::CH_W:0] diff;
        for (int c = 0; c < crmp_pkg::N_CH; c++)
        begin
            lo2_next[c]   = lo_entry[crmp_pkg::ENTRY_W-1-c*crmp_pkg::CH_W -: crmp_pkg::CH_W];
            diff          = $signed({1'b0,
                            up_entry[crmp_pkg::ENTRY_W-1-c*crmp_pkg::CH_W -: crmp_pkg::CH_W]})
                          - $signed({1'b0, lo2_next[c]});
            prod2_next[c] = crmp_pkg::MIX_W'(diff * $signed({1'b0, w1_reg}));
        end
    end

    // add the base, round half up, saturate at the channel maximum, drop the fraction
    always_comb
    begin
        logic signed [crmp_pkg::MIX_W-1:0] acc;
        for (int c = 0; c < crmp_pkg::N_CH; c++)
        begin
            acc = $signed({HI_W'(0), lo2_reg[c], crmp_pkg::FRAC_W'(0)})
                + prod2_reg[c]
                + $signed(crmp_pkg::MIX_W'(1 << (crmp_pkg::FRAC_W - 1)));
            if (acc[crmp_pkg::MIX_W-1:crmp_pkg::CH_W+crmp_pkg::FRAC_W] != '0)
            begin
                col3_next[c] = '1;
            end
            else
            begin
                col3_next[c] = acc[crmp_pkg::CH_W+crmp_pkg::FRAC_W-1:crmp_pkg::FRAC_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            w1_reg <= weight;
        end
        if (en2)
        begin
            lo2_reg   <= lo2_next;
            prod2_reg <= prod2_next;
        end
        if (en3)
        begin
            col3_reg <= col3_next;
        end
    end

    assign rsp.valid = v3_reg;
    assign rsp.red   = col3_reg[0];
    assign rsp.green = col3_reg[1];
    assign rsp.blue  = col3_reg[2];

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rsp.ready) |=> v3_reg)
        else $error("waiting result dropped");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !en1 |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with an empty stage");

    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.ready |-> en1)
        else $error("input stalled while output drains");

endmodule

// ===== rtl/color_ramp_interpolator_top.sv =====
// Channel   Direction  Handshake        Payload
// req       in         valid / ready    operation, position, write_index, write_red/green/blue
// rsp       out        valid / ready    red, green, blue
// cfg       in         cfg_we           cfg_wdata = entry_count
//
// One item per cycle sustained while rsp takes results; a lookup result passes the
// palette read register (loaded at its transfer edge), the channel multiply register
// and the round and output register before it is valid on rsp.
// Write items update the palette at their transfer and give no result.
// Reset clears the stage valids and sets entry_count to 2; the palette is not cleared.
// Stalls on rsp fill empty stages first; req ready drops only when all three are full.
module color_ramp_interpolator_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [crmp_pkg::COUNT_W-1:0]  cfg_wdata,
    crmp_in_if.sink                       req,
    crmp_out_if.source                    rsp
);

    logic [crmp_pkg::COUNT_W-1:0] entry_count_reg;
    crmp_pkg::crmp_addr_t         addr;
    logic                         advance;
    logic                         xfer;
    logic                         is_write;
    logic [crmp_pkg::ENTRY_W-1:0] lo_entry;
    logic [crmp_pkg::ENTRY_W-1:0] up_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= crmp_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_wdata;
        end
    end

    // take a new item whenever the first stage can move
    assign req.ready = advance;
    assign xfer      = req.valid && req.ready;
    assign is_write  = (req.operation == crmp_pkg::OP_WRITE);

    crmp_addr u_addr
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_count (entry_count_reg),
        .position    (req.position),
        .addr        (addr)
    );

    // A write and a lookup never share a transfer, so a lookup right after a
    // write to the same entry already reads the new data: no forwarding needed.
    crmp_palette_ram u_ram
    (
        .clk     (clk),
        .we      (xfer && is_write),
        .waddr   (req.write_index[crmp_pkg::IDX_W-1:0]),
        .wdata   ({req.write_red, req.write_green, req.write_blue}),
        .re      (advance),
        .raddr_a (addr.lo_idx),
        .raddr_b (addr.up_idx),
        .rdata_a (lo_entry),
        .rdata_b (up_entry)
    );

    crmp_mix u_mix
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (req.valid && !is_write),
        .weight   (addr.weight),
        .lo_entry (lo_entry),
        .up_entry (up_entry),
        .advance  (advance),
        .rsp      (rsp)
    );

endmodule

// ===== tb/sv/color_ramp_interpolator_top_tb.sv =====
`timescale 1ns / 1ps

module color_ramp_interpolator_top_tb;

    // Abort well beyond the slowest legal run: ~410 items, each with a long
    // sender gap, a long sink stall and the pipeline latency, plus drains.
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned POS_ONE     = 1 << crmp_pkg::FRAC_W;
    localparam int unsigned POS_HALF    = 1 << (crmp_pkg::FRAC_W - 1);
    localparam int unsigned PIPE_DRAIN  = 4;

    typedef struct packed
    {
        logic [crmp_pkg::CH_W-1:0] red;
        logic [crmp_pkg::CH_W-1:0] green;
        logic [crmp_pkg::CH_W-1:0] blue;
    } rgb_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [crmp_pkg::COUNT_W-1:0]  cfg_wdata;

    crmp_in_if  req_if ();
    crmp_out_if rsp_if ();

    color_ramp_interpolator_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // Shadow of the block's state: palette contents and the ramp length register.
    logic [crmp_pkg::ENTRY_W-1:0]  palette_copy [crmp_pkg::PAL_DEPTH];
    logic [crmp_pkg::COUNT_W-1:0]  ramp_len;

    // Colors owed by the block, oldest first.
    rgb_t                pending_colors [$];

    // Shared knobs between the test tasks and the sink process.
    bit                  idling_on;
    int unsigned         sink_hold_req;

    int unsigned         errors;
    int unsigned         cycle_count;
    int unsigned         writes_done;
    int unsigned         lookups_done;
    int unsigned         colors_checked;
    int unsigned         len_writes;
    int unsigned         input_stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Effective top index of the ramp: a length of zero acts as one entry,
    // a length above the palette depth saturates at the depth.
    function automatic int unsigned ramp_span();
        if (ramp_len == 0)
            return 0;
        if (ramp_len > crmp_pkg::PAL_DEPTH)
            return crmp_pkg::PAL_DEPTH - 1;
        return ramp_len - 1;
    endfunction

    // Expected color for one lookup at the current ramp length and palette.
    function automatic rgb_t ramp_color(input logic [crmp_pkg::POS_W-1:0] pos);
        int unsigned                  span;
        int unsigned                  scaled;
        int unsigned                  upper;
        int unsigned                  lower;
        int unsigned                  weight;
        int unsigned                  acc;
        int unsigned                  chan;
        logic [crmp_pkg::ENTRY_W-1:0] lo_entry;
        logic [crmp_pkg::ENTRY_W-1:0] up_entry;
        logic [crmp_pkg::ENTRY_W-1:0] mixed;

        span = ramp_span();
        if (pos == 0 || span == 0)
            mixed = palette_copy[0];
        else if (pos >= POS_ONE)
            mixed = palette_copy[span];
        else
        begin
            // Upper index is the ceiling of the scaled position, capped at the top
            scaled = pos * span;
            upper  = (scaled + POS_ONE - 1) >> crmp_pkg::FRAC_W;
            if (upper > span)
                upper = span;
            if (upper < 1)
                upper = 1;
            lower  = upper - 1;
            weight = scaled - (lower << crmp_pkg::FRAC_W);
            if (weight > POS_ONE)
                weight = POS_ONE;
            lo_entry = palette_copy[lower];
            up_entry = palette_copy[upper];
            for (int ch = 0; ch < crmp_pkg::N_CH; ch++)
            begin
                // Round half up, clamp to a byte
                acc  = lo_entry[ch*crmp_pkg::CH_W +: crmp_pkg::CH_W] * (POS_ONE - weight)
                     + up_entry[ch*crmp_pkg::CH_W +: crmp_pkg::CH_W] * weight;
                chan = (acc + POS_HALF) >> crmp_pkg::FRAC_W;
                if (chan > 255)
                    chan = 255;
                mixed[ch*crmp_pkg::CH_W +: crmp_pkg::CH_W] = chan[crmp_pkg::CH_W-1:0];
            end
        end
        return rgb_t'(mixed);
    endfunction

    // Gap length: mostly short, now and then long.
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Position mix: endpoints, saturation, interval seams and uniform interior.
    function automatic logic [crmp_pkg::POS_W-1:0] pick_position();
        int unsigned span;
        int unsigned sel;
        int unsigned k;
        int unsigned p;

        span = ramp_span();
        sel  = $urandom_range(0, 99);
        if (sel < 8)
            return '0;
        if (sel < 16)
            return crmp_pkg::POS_W'(POS_ONE);
        if (sel < 22)
            return crmp_pkg::POS_W'($urandom_range(POS_ONE + 1, (1 << crmp_pkg::POS_W) - 1));
        if (sel < 40 && span > 1)
        begin
            // Land on or next to a seam between two palette entries
            k = $urandom_range(1, span - 1);
            p = (k * POS_ONE) / span + $urandom_range(0, 2) - 1;
            return crmp_pkg::POS_W'(p);
        end
        return crmp_pkg::POS_W'($urandom_range(1, POS_ONE - 1));
    endfunction

    function automatic logic [crmp_pkg::ENTRY_W-1:0] pick_entry();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return crmp_pkg::ENTRY_W'($urandom());
        endcase
    endfunction

    // Offer one item at the falling edge, hold it until the transfer, then
    // update the shadow state exactly as the block sees it. Valid is left high;
    // the next send, pause or drain decides what happens at the next falling edge.
    task automatic send_item(input crmp_pkg::crmp_op_t op,
                             input logic [crmp_pkg::POS_W-1:0] pos,
                             input logic [crmp_pkg::WIDX_W-1:0] idx,
                             input logic [crmp_pkg::ENTRY_W-1:0] rgb);
        @(negedge clk);
        req_if.valid       = 1'b1;
        req_if.operation   = op;
        req_if.position    = pos;
        req_if.write_index = idx;
        req_if.write_red   = rgb[23:16];
        req_if.write_green = rgb[15:8];
        req_if.write_blue  = rgb[7:0];
        do
            @(posedge clk);
        while (!req_if.ready);
        if (op == crmp_pkg::OP_WRITE)
        begin
            palette_copy[idx] = rgb;
            writes_done++;
        end
        else
        begin
            pending_colors.push_back(ramp_color(pos));
            lookups_done++;
        end
    endtask

    // Lookups carry random write fields and writes a random position: the
    // block must ignore whichever fields the operation does not use.
    task automatic write_entry(input logic [crmp_pkg::WIDX_W-1:0] idx,
                               input logic [crmp_pkg::ENTRY_W-1:0] rgb);
        send_item(crmp_pkg::OP_WRITE, crmp_pkg::POS_W'($urandom()), idx, rgb);
    endtask

    task automatic lookup(input logic [crmp_pkg::POS_W-1:0] pos);
        send_item(crmp_pkg::OP_LOOKUP, pos, crmp_pkg::WIDX_W'($urandom()),
                  crmp_pkg::ENTRY_W'($urandom()));
    endtask

    task automatic pause_sender(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            req_if.valid = 1'b0;
        end
    endtask

    task automatic maybe_pause();
        if (idling_on && $urandom_range(0, 2) == 0)
            pause_sender(idle_len());
    endtask

    // Drop valid and hold until every owed color has arrived, then let the
    // pipeline settle so that no write item is still on its way.
    task automatic drain();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic set_ramp_len(input logic [crmp_pkg::COUNT_W-1:0] len);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = len;
        @(negedge clk);
        cfg_we    = 1'b0;
        ramp_len  = len;
        len_writes++;
    endtask

    // Fill the whole palette so no lookup can ever touch an unwritten entry.
    // Entry 0 is black and entry 1 white, so the reset ramp spans the full range.
    task automatic test_palette_load();
        write_entry(crmp_pkg::WIDX_W'(0), '0);
        write_entry(crmp_pkg::WIDX_W'(1), '1);
        for (int i = 2; i < crmp_pkg::PAL_DEPTH; i++)
            write_entry(crmp_pkg::WIDX_W'(i), i == crmp_pkg::PAL_DEPTH - 1 ? '1 : pick_entry());
    endtask

    // Reset ramp length: zero, the half-up rounding point, both sides of 1.0
    // and a position far into saturation.
    task automatic test_ramp_endpoints();
        lookup('0);
        lookup(crmp_pkg::POS_W'(POS_HALF - 1));
        lookup(crmp_pkg::POS_W'(POS_HALF));
        lookup(crmp_pkg::POS_W'(POS_ONE - 1));
        lookup(crmp_pkg::POS_W'(POS_ONE));
        lookup('1);
    endtask

    // Single entry, a zero length and a length beyond the palette depth.
    task automatic test_short_ramps();
        set_ramp_len(crmp_pkg::COUNT_W'(1));
        lookup(crmp_pkg::POS_W'(40000));
        lookup(crmp_pkg::POS_W'(POS_ONE));
        set_ramp_len('0);
        lookup(crmp_pkg::POS_W'(12345));
        set_ramp_len('1);
        lookup(crmp_pkg::POS_W'(POS_ONE));
        lookup(crmp_pkg::POS_W'(30000));
    endtask

    // Stall the sink for a long stretch while the sender keeps offering
    // back-to-back lookups, so the pipeline fills and req ready drops.
    task automatic test_output_backpressure();
        set_ramp_len(crmp_pkg::COUNT_W'(crmp_pkg::PAL_DEPTH));
        idling_on     = 1'b0;
        sink_hold_req = 64;
        repeat (24)
            lookup(pick_position());
        idling_on     = 1'b1;
    endtask

    // Let the sender stop until every color is back, then carry on.
    task automatic test_sender_pause();
        repeat (10)
        begin
            maybe_pause();
            lookup(pick_position());
        end
        drain();
        repeat (10)
        begin
            maybe_pause();
            lookup(pick_position());
        end
    endtask

    // Mixed writes and lookups over a sequence of ramp lengths. Each phase
    // opens with a burst without idling on either side.
    task automatic test_random_traffic();
        logic [crmp_pkg::COUNT_W-1:0] lens [8];

        lens = '{5'd16, 5'd2, 5'd5, 5'd1, 5'd0, 5'd31,
                 crmp_pkg::COUNT_W'($urandom_range(3, 15)), 5'd16};
        foreach (lens[p])
        begin
            set_ramp_len(lens[p]);
            for (int i = 0; i < 42; i++)
            begin
                idling_on = (i >= 12);
                maybe_pause();
                if ($urandom_range(0, 3) == 0)
                    write_entry(crmp_pkg::WIDX_W'($urandom()), pick_entry());
                else
                    lookup(pick_position());
            end
        end
        idling_on = 1'b1;
    endtask

    // Sink: hold ready low for the requested stretch, otherwise stall at random.
    initial
    begin : color_sink
        int unsigned hold;

        hold          = 0;
        rsp_if.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold_req != 0)
            begin
                hold          = sink_hold_req;
                sink_hold_req = 0;
            end
            else if (hold == 0 && idling_on && $urandom_range(0, 2) == 0)
                hold = idle_len();
            if (hold != 0)
            begin
                rsp_if.ready = 1'b0;
                hold--;
            end
            else
                rsp_if.ready = 1'b1;
        end
    end

    function automatic void check_channel(input string name,
                                          input logic [crmp_pkg::CH_W-1:0] want,
                                          input logic [crmp_pkg::CH_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare every color transfer against the oldest owed color.
    always @(posedge clk)
    begin : color_check
        rgb_t want;

        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $display("%0t: unexpected color, expected none, actual %h %h %h",
                         $time, rsp_if.red, rsp_if.green, rsp_if.blue);
                errors++;
            end
            else
            begin
                want = pending_colors.pop_front();
                check_channel("red",   want.red,   rsp_if.red);
                check_channel("green", want.green, rsp_if.green);
                check_channel("blue",  want.blue,  rsp_if.blue);
                colors_checked++;
            end
        end
    end

    // Count cycles and req stalls; abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && req_if.valid && !req_if.ready)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d colors outstanding", $time, pending_colors.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        // Drive every input to a known value from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.operation   = crmp_pkg::OP_LOOKUP;
        req_if.position    = '0;
        req_if.write_index = '0;
        req_if.write_red   = '0;
        req_if.write_green = '0;
        req_if.write_blue  = '0;
        ramp_len           = crmp_pkg::COUNT_RESET;
        idling_on          = 1'b1;
        sink_hold_req      = 0;
        errors             = 0;
        cycle_count        = 0;
        writes_done        = 0;
        lookups_done       = 0;
        colors_checked     = 0;
        len_writes         = 0;
        input_stall_cycles = 0;
        foreach (palette_copy[i])
            palette_copy[i] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_palette_load();
        test_ramp_endpoints();
        test_short_ramps();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();

        // Wait out every owed color, then keep watching for strays
        drain();
        repeat (8) @(posedge clk);

        $display("Ran %0d palette writes and %0d lookups over %0d ramp length settings.",
                 writes_done, lookups_done, len_writes);
        $display("Checked %0d colors; req was held off for %0d cycles.",
                 colors_checked, input_stall_cycles);
        if (errors == 0 && pending_colors.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/crmp_pkg.sv
rtl/crmp_in_if.sv
rtl/crmp_out_if.sv
rtl/crmp_addr.sv
rtl/crmp_palette_ram.sv
rtl/crmp_mix.sv
rtl/color_ramp_interpolator_top.sv
tb/sv/color_ramp_interpolator_top_tb.sv
